FILE: hdl/wwa_pkg.sv
`default_nettype none
package wwa_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_SDIV = 4'd5,
    OP_SMOD = 4'd6,
    OP_EXP  = 4'd7,
    OP_SHL  = 4'd8,
    OP_SHR  = 4'd9,
    OP_OR   = 4'd10,
    OP_AND  = 4'd11,
    OP_XOR  = 4'd12,
    OP_NOT  = 4'd13,
    OP_BYTE = 4'd14,
    OP_NONE = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } ord_t;

  typedef enum logic [1:0] {
    CLS_DIRECT = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2,
    CLS_EXP    = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL,
    BK_DIV,
    BK_EXP_SQ,
    BK_EXP_MUL,
    BK_FIX,
    BK_DONE
  } bk_state_t;

  localparam int MAX_BITS = 256;

endpackage
`default_nettype wire

FILE: hdl/wwa_front.sv
`default_nettype none
module wwa_front #(
  parameter int WBITS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [3:0]       mode,
  input  wire logic [255:0]     a_in,
  input  wire logic [255:0]     b_in,
  output logic                  q_valid,
  input  wire logic             q_take,
  output logic [3:0]            q_mode,
  output wwa_pkg::cls_t         q_cls,
  output logic [WBITS-1:0]      q_a,
  output logic [WBITS-1:0]      q_b,
  output logic [WBITS-1:0]      q_direct,
  output wwa_pkg::ord_t         q_ord
);

  localparam int WBYTES = WBITS / 8;
  localparam int SHW = $clog2(WBITS);
  localparam int BYW = $clog2(WBYTES);

  logic [WBITS-1:0] a, b, direct;
  wwa_pkg::cls_t cls;
  wwa_pkg::ord_t ord;
  logic b_small_sh, b_small_by;
  logic [SHW-1:0] sh;
  logic [BYW-1:0] pos;
  logic [7:0] sel_byte;

  assign a = a_in[WBITS-1:0];
  assign b = b_in[WBITS-1:0];
  assign b_small_sh = (b < WBITS);
  assign b_small_by = (b < WBYTES);
  assign sh = b[SHW-1:0];
  assign pos = BYW'(WBYTES - 1) - b[BYW-1:0];
  assign sel_byte = a[{pos, 3'b000} +: 8];

  always_comb begin
    cls = wwa_pkg::CLS_DIRECT;
    direct = '0;
    unique case (mode) inside
      wwa_pkg::OP_ADD: direct = a + b;
      wwa_pkg::OP_SUB: direct = a - b;
      wwa_pkg::OP_OR:  direct = a | b;
      wwa_pkg::OP_AND: direct = a & b;
      wwa_pkg::OP_XOR: direct = a ^ b;
      wwa_pkg::OP_NOT: direct = ~a;
      wwa_pkg::OP_SHL: direct = b_small_sh ? (a << sh) : '0;
      wwa_pkg::OP_SHR: direct = b_small_sh ? (a >> sh) : '0;
      wwa_pkg::OP_BYTE: direct = b_small_by ? WBITS'(sel_byte) : '0;
      wwa_pkg::OP_MUL: cls = wwa_pkg::CLS_MUL;
      wwa_pkg::OP_DIV, wwa_pkg::OP_MOD, wwa_pkg::OP_SDIV, wwa_pkg::OP_SMOD:
        cls = wwa_pkg::CLS_DIV;
      wwa_pkg::OP_EXP: cls = wwa_pkg::CLS_EXP;
      default: direct = '0;
    endcase
    if (a < b) ord = wwa_pkg::ORD_LESS;
    else if (a == b) ord = wwa_pkg::ORD_EQUAL;
    else ord = wwa_pkg::ORD_GREATER;
  end

  assign busy = q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (start && !busy) begin
      q_valid <= 1'b1;
    end else if (q_take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q_mode <= mode;
      q_cls <= cls;
      q_a <= a;
      q_b <= b;
      q_direct <= direct;
      q_ord <= ord;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/wwa_back.sv
`default_nettype none
module wwa_back #(
  parameter int WBITS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_take,
  input  wire logic [3:0]       q_mode,
  input  wire wwa_pkg::cls_t    q_cls,
  input  wire logic [WBITS-1:0] q_a,
  input  wire logic [WBITS-1:0] q_b,
  input  wire logic [WBITS-1:0] q_direct,
  input  wire wwa_pkg::ord_t    q_ord,
  output logic                  done,
  output logic [WBITS-1:0]      res,
  output wwa_pkg::ord_t         res_ord,
  output logic                  idle
);

  localparam int CW = $clog2(WBITS) + 1;

  wwa_pkg::bk_state_t state, state_next;
  logic [3:0] op;
  wwa_pkg::cls_t cls;
  logic [WBITS-1:0] ra, rb, acc, base, expo, mcand, mplier, prod;
  logic [WBITS-1:0] rem, quo, dvs;
  logic [CW-1:0] cnt;
  logic sa, sb, bzero;
  logic [WBITS:0] rem_sh, rem_diff;
  logic [WBITS-1:0] ua, ub;
  logic sign_op;

  assign sign_op = (op == wwa_pkg::OP_SDIV) || (op == wwa_pkg::OP_SMOD);
  assign ua = (sign_op && ra[WBITS-1]) ? -ra : ra;
  assign ub = (sign_op && rb[WBITS-1]) ? -rb : rb;
  assign rem_sh = {rem, quo[WBITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};

  assign q_take = (state == wwa_pkg::BK_IDLE) && q_valid;
  assign idle = (state == wwa_pkg::BK_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= wwa_pkg::BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wwa_pkg::BK_IDLE: if (q_valid) state_next = wwa_pkg::BK_LOAD;
      wwa_pkg::BK_LOAD: begin
        unique case (cls)
          wwa_pkg::CLS_DIRECT: state_next = wwa_pkg::BK_DONE;
          wwa_pkg::CLS_MUL: state_next = wwa_pkg::BK_MUL;
          wwa_pkg::CLS_DIV: state_next = bzero ? wwa_pkg::BK_DONE : wwa_pkg::BK_DIV;
          wwa_pkg::CLS_EXP: state_next = wwa_pkg::BK_EXP_MUL;
          default: state_next = wwa_pkg::BK_DONE;
        endcase
      end
      wwa_pkg::BK_MUL: if (cnt == CW'(WBITS - 1)) state_next = wwa_pkg::BK_DONE;
      wwa_pkg::BK_DIV: if (cnt == CW'(WBITS - 1)) state_next = wwa_pkg::BK_FIX;
      wwa_pkg::BK_EXP_MUL: begin
        if (cnt == CW'(WBITS - 1)) begin
          state_next = wwa_pkg::BK_EXP_SQ;
        end
      end
      wwa_pkg::BK_EXP_SQ: begin
        if (cnt == CW'(WBITS - 1)) begin
          state_next = ((expo >> 1) == '0) ? wwa_pkg::BK_DONE : wwa_pkg::BK_EXP_MUL;
        end
      end
      wwa_pkg::BK_FIX: state_next = wwa_pkg::BK_DONE;
      wwa_pkg::BK_DONE: state_next = wwa_pkg::BK_IDLE;
      default: state_next = wwa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      wwa_pkg::BK_IDLE: begin
        if (q_valid) begin
          op <= q_mode;
          cls <= q_cls;
          ra <= q_a;
          rb <= q_b;
          res <= q_direct;
          res_ord <= q_ord;
          bzero <= (q_b == '0);
        end
      end
      wwa_pkg::BK_LOAD: begin
        cnt <= '0;
        prod <= '0;
        mcand <= ra;
        mplier <= rb;
        sa <= sign_op && ra[WBITS-1];
        sb <= sign_op && rb[WBITS-1];
        quo <= ua;
        dvs <= ub;
        rem <= '0;
        acc <= WBITS'(1);
        base <= ra;
        expo <= rb;
        if (bzero && cls == wwa_pkg::CLS_DIV) res <= '0;
      end
      wwa_pkg::BK_MUL: begin
        cnt <= cnt + CW'(1);
        prod <= mplier[0] ? prod + mcand : prod;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
        if (cnt == CW'(WBITS - 1)) res <= mplier[0] ? prod + mcand : prod;
      end
      wwa_pkg::BK_DIV: begin
        cnt <= cnt + CW'(1);
        if (!rem_diff[WBITS]) begin
          rem <= rem_diff[WBITS-1:0];
          quo <= {quo[WBITS-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WBITS-1:0];
          quo <= {quo[WBITS-2:0], 1'b0};
        end
      end
      wwa_pkg::BK_FIX: begin
        unique case (op)
          wwa_pkg::OP_DIV: res <= quo;
          wwa_pkg::OP_MOD: res <= rem;
          wwa_pkg::OP_SDIV: res <= (sa != sb) ? -quo : quo;
          default: res <= sa ? -rem : rem;
        endcase
      end
      wwa_pkg::BK_EXP_MUL: begin
        cnt <= (cnt == CW'(WBITS - 1)) ? '0 : cnt + CW'(1);
        if (cnt == '0) begin
          prod <= (expo[0] && base[0]) ? acc : '0;
          mcand <= acc << 1;
          mplier <= base >> 1;
        end else begin
          prod <= mplier[0] ? prod + mcand : prod;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
        end
        if (cnt == CW'(WBITS - 1)) begin
          if (expo[0]) acc <= mplier[0] ? prod + mcand : prod;
        end
      end
      wwa_pkg::BK_EXP_SQ: begin
        cnt <= (cnt == CW'(WBITS - 1)) ? '0 : cnt + CW'(1);
        if (cnt == '0) begin
          prod <= base[0] ? base : '0;
          mcand <= base << 1;
          mplier <= base >> 1;
        end else begin
          prod <= mplier[0] ? prod + mcand : prod;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
        end
        if (cnt == CW'(WBITS - 1)) begin
          base <= mplier[0] ? prod + mcand : prod;
          expo <= expo >> 1;
          if ((expo >> 1) == '0) res <= acc;
        end
      end
      default: begin
      end
    endcase
  end

  assign done = (state == wwa_pkg::BK_DONE);

  property p_take_idle;
    @(posedge clk) disable iff (rst) q_take |=> (state == wwa_pkg::BK_LOAD);
  endproperty
  a_take_idle: assert property (p_take_idle) else $error("take outside idle");

  property p_done_once;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_once: assert property (p_done_once) else $error("double result");

  property p_div_end;
    @(posedge clk) disable iff (rst)
      (state == wwa_pkg::BK_FIX) |=> (state == wwa_pkg::BK_DONE);
  endproperty
  a_div_end: assert property (p_div_end) else $error("fix step stalled");

endmodule
`default_nettype wire

FILE: hdl/wide_word_alu_256.sv
// wide_word_alu_256: 256-bit word ALU with a command interface.
// Drive mode, a_limb0..3 and b_limb0..3 and pulse start while busy is low;
// the request is taken at that edge. A front stage classifies the request
// and computes the direct operations (add, sub, logic, shifts, byte)
// and the unsigned ordering, then parks it in a one-entry queue. The back
// stage drains the queue and runs a shift-and-add multiplier and a
// bit-serial restoring divider, one bit per cycle.
// Exp runs square and multiply, each pass a shift-and-add multiply through
// the shared adder, and the exp loop stops once the remaining exponent bits
// are zero; a zero divisor skips the divider and yields zero.
// busy stays high while the queue entry is held; the front accepts a new
// request as soon as the back has taken the previous one.
// Each result appears for one cycle with done high; the receiver cannot
// stall it. Synchronous reset rst clears the queue and back state.
`default_nettype none
module wide_word_alu_256 #(
  parameter int WORD_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  mode,
  input  wire logic [63:0] a_limb0,
  input  wire logic [63:0] a_limb1,
  input  wire logic [63:0] a_limb2,
  input  wire logic [63:0] a_limb3,
  input  wire logic [63:0] b_limb0,
  input  wire logic [63:0] b_limb1,
  input  wire logic [63:0] b_limb2,
  input  wire logic [63:0] b_limb3,
  output logic             done,
  output logic [63:0]      result_limb0,
  output logic [63:0]      result_limb1,
  output logic [63:0]      result_limb2,
  output logic [63:0]      result_limb3,
  output logic [1:0]       ordering
);

  localparam int WBITS = WORD_BYTES * 8;

  logic q_valid, q_take, bk_idle;
  logic [3:0] q_mode;
  wwa_pkg::cls_t q_cls;
  logic [WBITS-1:0] q_a, q_b, q_direct, res;
  wwa_pkg::ord_t q_ord, res_ord;
  logic [255:0] res_full;

  wwa_front #(.WBITS(WBITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .a_in({a_limb3, a_limb2, a_limb1, a_limb0}),
    .b_in({b_limb3, b_limb2, b_limb1, b_limb0}),
    .q_valid(q_valid), .q_take(q_take), .q_mode(q_mode), .q_cls(q_cls),
    .q_a(q_a), .q_b(q_b), .q_direct(q_direct), .q_ord(q_ord)
  );

  wwa_back #(.WBITS(WBITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take),
    .q_mode(q_mode), .q_cls(q_cls), .q_a(q_a), .q_b(q_b),
    .q_direct(q_direct), .q_ord(q_ord), .done(done), .res(res),
    .res_ord(res_ord), .idle(bk_idle)
  );

  assign res_full = 256'(res);
  assign result_limb0 = res_full[63:0];
  assign result_limb1 = res_full[127:64];
  assign result_limb2 = res_full[191:128];
  assign result_limb3 = res_full[255:192];
  assign ordering = res_ord;

  property p_busy_q;
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy;
  endproperty
  a_busy_q: assert property (p_busy_q) else $error("request not queued");

  property p_done_back;
    @(posedge clk) disable iff (rst) done |=> bk_idle;
  endproperty
  a_done_back: assert property (p_done_back) else $error("back not idle");

  property p_ord_code;
    @(posedge clk) disable iff (rst) done |-> (ordering != 2'd3);
  endproperty
  a_ord_code: assert property (p_ord_code) else $error("bad ordering");

endmodule
`default_nettype wire

FILE: test/tb_wide_word_alu_256.sv
`timescale 1ns / 100ps
module tb_wide_word_alu_256;

  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic [255:0]  word;
    wwa_pkg::ord_t ord;
  } alu_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  mode;
  logic [63:0] a_limb0, a_limb1, a_limb2, a_limb3;
  logic [63:0] b_limb0, b_limb1, b_limb2, b_limb3;
  logic        done;
  logic [63:0] result_limb0, result_limb1, result_limb2, result_limb3;
  logic [1:0]  ordering;

  alu_result_t pending_results[$];
  int          mismatches;
  int          stall_cycles;
  bit          steady;

  wide_word_alu_256 dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .a_limb0(a_limb0), .a_limb1(a_limb1), .a_limb2(a_limb2), .a_limb3(a_limb3),
    .b_limb0(b_limb0), .b_limb1(b_limb1), .b_limb2(b_limb2), .b_limb3(b_limb3),
    .done(done),
    .result_limb0(result_limb0), .result_limb1(result_limb1),
    .result_limb2(result_limb2), .result_limb3(result_limb3),
    .ordering(ordering)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [255:0] negate(logic [255:0] v);
    return 256'd0 - v;
  endfunction

  function automatic logic [255:0] power(logic [255:0] base, logic [255:0] ex);
    logic [255:0] acc;
    acc = 256'd1;
    for (int i = 0; i < 256; i++) begin
      if (ex[i]) acc = acc * base;
      base = base * base;
    end
    return acc;
  endfunction

  function automatic alu_result_t compute_alu(wwa_pkg::op_t op, logic [255:0] a,
                                              logic [255:0] b);
    alu_result_t  res;
    logic [255:0] ua, ub, q, m;
    logic [7:0]   pos;
    ua = a[255] ? negate(a) : a;
    ub = b[255] ? negate(b) : b;
    res.word = '0;
    case (op)
      wwa_pkg::OP_ADD: res.word = a + b;
      wwa_pkg::OP_SUB: res.word = a - b;
      wwa_pkg::OP_MUL: res.word = a * b;
      wwa_pkg::OP_DIV: if (b != 0) res.word = a / b;
      wwa_pkg::OP_MOD: if (b != 0) res.word = a % b;
      wwa_pkg::OP_SDIV: if (b != 0) begin
        q = ua / ub;
        res.word = (a[255] != b[255]) ? negate(q) : q;
      end
      wwa_pkg::OP_SMOD: if (b != 0) begin
        m = ua % ub;
        res.word = a[255] ? negate(m) : m;
      end
      wwa_pkg::OP_EXP: res.word = power(a, b);
      wwa_pkg::OP_SHL: if (b < 256) res.word = a << b[7:0];
      wwa_pkg::OP_SHR: if (b < 256) res.word = a >> b[7:0];
      wwa_pkg::OP_OR:  res.word = a | b;
      wwa_pkg::OP_AND: res.word = a & b;
      wwa_pkg::OP_XOR: res.word = a ^ b;
      wwa_pkg::OP_NOT: res.word = ~a;
      wwa_pkg::OP_BYTE: if (b < 32) begin
        pos = 8'd31 - b[7:0];
        res.word = {248'd0, a[pos*8 +: 8]};
      end
      default: res.word = '0;
    endcase
    res.ord = (a < b) ? wwa_pkg::ORD_LESS :
              ((a == b) ? wwa_pkg::ORD_EQUAL : wwa_pkg::ORD_GREATER);
    return res;
  endfunction

  function automatic logic [255:0] rand_full();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [255:0] rand_operand();
    logic [255:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = $urandom_range(0, 300);
      3: v = 256'd1 << $urandom_range(0, 255);
      4: v = {1'b1, 255'd0};
      5: v = negate($urandom_range(1, 1000));
      6: v = rand_full() >> $urandom_range(0, 255);
      default: v = rand_full();
    endcase
    return v;
  endfunction

  task automatic send_request(wwa_pkg::op_t op, logic [255:0] a, logic [255:0] b);
    if (!steady && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    mode <= op;
    {a_limb3, a_limb2, a_limb1, a_limb0} <= a;
    {b_limb3, b_limb2, b_limb1, b_limb0} <= b;
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_results.push_back(compute_alu(op, a, b));
  endtask

  always @(negedge clk) begin
    alu_result_t exp_res;
    logic [255:0] got;
    if (!rst) begin
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (done) begin
        got = {result_limb3, result_limb2, result_limb1, result_limb0};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h ord %0d", got, ordering);
        end else begin
          exp_res = pending_results.pop_front();
          if (got !== exp_res.word || ordering !== exp_res.ord) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h ord %0d, got %h ord %0d",
                       exp_res.word, exp_res.ord, got, ordering);
          end
        end
      end
    end
  end

  task automatic test_add_sub_mul();
    send_request(wwa_pkg::OP_ADD, '1, 256'd1);
    send_request(wwa_pkg::OP_ADD, '0, '0);
    send_request(wwa_pkg::OP_SUB, '0, 256'd1);
    send_request(wwa_pkg::OP_SUB, '1, '1);
    send_request(wwa_pkg::OP_MUL, '1, '1);
    send_request(wwa_pkg::OP_MUL, {1'b1, 255'd0}, 256'd2);
  endtask

  task automatic test_division();
    send_request(wwa_pkg::OP_DIV, '1, '0);
    send_request(wwa_pkg::OP_MOD, 256'd77, '0);
    send_request(wwa_pkg::OP_SDIV, {1'b1, 255'd0}, '0);
    send_request(wwa_pkg::OP_SMOD, '1, '0);
    send_request(wwa_pkg::OP_DIV, '1, 256'd3);
    send_request(wwa_pkg::OP_SDIV, {1'b1, 255'd0}, '1);
    send_request(wwa_pkg::OP_SDIV, negate(256'd7), 256'd2);
    send_request(wwa_pkg::OP_SMOD, negate(256'd7), 256'd2);
    send_request(wwa_pkg::OP_SMOD, 256'd7, negate(256'd2));
  endtask

  task automatic test_exponent();
    send_request(wwa_pkg::OP_EXP, '0, '0);
    send_request(wwa_pkg::OP_EXP, 256'd3, 256'd200);
    send_request(wwa_pkg::OP_EXP, 256'd3, '1);
  endtask

  task automatic test_shift_logic_byte();
    send_request(wwa_pkg::OP_SHL, '1, 256'd255);
    send_request(wwa_pkg::OP_SHL, '1, 256'd256);
    send_request(wwa_pkg::OP_SHR, '1, 256'd255);
    send_request(wwa_pkg::OP_SHR, '1, {1'b1, 255'd0});
    send_request(wwa_pkg::OP_OR, rand_full(), rand_full());
    send_request(wwa_pkg::OP_AND, rand_full(), rand_full());
    send_request(wwa_pkg::OP_XOR, rand_full(), rand_full());
    send_request(wwa_pkg::OP_NOT, '0, '1);
    send_request(wwa_pkg::OP_BYTE, rand_full(), 256'd0);
    send_request(wwa_pkg::OP_BYTE, rand_full(), 256'd31);
    send_request(wwa_pkg::OP_BYTE, '1, 256'd32);
    send_request(wwa_pkg::OP_BYTE, '1, {64'd1, 192'd0});
  endtask

  task automatic test_random_ops(int count);
    wwa_pkg::op_t op;
    logic [255:0] a, b;
    for (int n = 0; n < count; n++) begin
      steady = (n >= 400 && n < 600);
      op = wwa_pkg::op_t'($urandom_range(0, 14));
      a = rand_operand();
      b = rand_operand();
      case (op)
        wwa_pkg::OP_EXP: b = (n == count / 2) ? rand_full() : $urandom_range(0, 15);
        wwa_pkg::OP_SHL, wwa_pkg::OP_SHR:
          if ($urandom_range(0, 3) != 0) b = $urandom_range(0, 300);
        wwa_pkg::OP_BYTE: if ($urandom_range(0, 3) != 0) b = $urandom_range(0, 40);
        default: if ($urandom_range(0, 7) == 0) b = a;
      endcase
      send_request(op, a, b);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode = wwa_pkg::OP_ADD;
    {a_limb3, a_limb2, a_limb1, a_limb0} = '0;
    {b_limb3, b_limb2, b_limb1, b_limb0} = '0;
    mismatches = 0;
    stall_cycles = 0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_add_sub_mul();
    test_division();
    test_exponent();
    test_shift_logic_byte();
    test_random_ops(1140);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/wwa_pkg.sv
hdl/wwa_front.sv
hdl/wwa_back.sv
hdl/wide_word_alu_256.sv
test/tb_wide_word_alu_256.sv
